// File: hdl/page_frame_replacement_top_macros.svh
// assertion macros shared by the checker
`ifndef PAGE_FRAME_REPLACEMENT_TOP_MACROS_SVH
`define PAGE_FRAME_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define PFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfr assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfr assertion failed");

`endif

// File: hdl/pfr_pkg.sv
package pfr_pkg;

  localparam int unsigned NumFramesDef = 4;
  localparam int unsigned PageBitsDef  = 16;
  localparam int unsigned PageInW      = 16;
  localparam int unsigned CntW         = 32;
  localparam int unsigned FrameOutW    = 2;

  localparam logic PolicyLru  = 1'b0;
  localparam logic PolicyFifo = 1'b1;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic commit;
    logic use_victim;
    logic start_scan;
    logic scan_step;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic policy_fifo;
    logic scan_last;
    logic out_free;
  } sts_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

// File: hdl/pfr_ctrl.sv
module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_LOOK;
        end
        S_LOOK: begin
          if (sts_i.hit || sts_i.policy_fifo) begin
            if (sts_i.out_free) state_q <= S_IDLE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_LOOK: begin
        if (sts_i.hit || sts_i.policy_fifo) begin
          cmd_o.commit = sts_i.out_free;
        end else begin
          cmd_o.start_scan = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_UPDATE: begin
        cmd_o.commit     = sts_i.out_free;
        cmd_o.use_victim = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/pfr_dp.sv
module pfr_dp
  import pfr_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic [PageInW-1:0]   page_number_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [FrameOutW-1:0] frame_index_o,
  output logic                 page_fault_o,
  output logic [CntW-1:0]      reference_total_o,
  output logic [CntW-1:0]      fault_total_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  localparam int unsigned FW   = $clog2(NUM_FRAMES);
  localparam int unsigned ExtW = PAGE_BITS + PageInW;

  logic                 mode_q, mode_lat_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] frame_page_q [NUM_FRAMES];
  logic                 frame_valid_q [NUM_FRAMES];
  logic [CntW-1:0]      frame_age_q [NUM_FRAMES];
  logic [FW-1:0]        fifo_ptr_q;
  logic [CntW-1:0]      ref_cnt_q, flt_cnt_q;
  logic [FW-1:0]        cnt_q, best_q;
  logic [CntW-1:0]      best_age_q;
  logic                 out_valid_q;
  logic [FrameOutW-1:0] frame_out_q;
  logic                 fault_out_q;

  logic [ExtW-1:0]      page_ext;
  logic [PAGE_BITS-1:0] page_in;
  logic                 hit;
  logic [FW-1:0]        hit_idx;
  logic [CntW-1:0]      age_rd;
  logic                 fault;
  logic [FW-1:0]        sel_frame;
  logic [FW+1:0]        sel_ext;

  assign page_ext = ExtW'(page_number_i);
  assign page_in  = page_ext[PAGE_BITS-1:0];

  // associative lookup, highest matching frame wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_valid_q[i] && (frame_page_q[i] == page_q)) begin
        hit     = 1'b1;
        hit_idx = FW'(i);
      end
    end
  end

  assign age_rd    = frame_age_q[cnt_q];
  assign fault     = cmd_i.use_victim || !hit;
  assign sel_frame = cmd_i.use_victim ? best_q : (hit ? hit_idx : fifo_ptr_q);
  assign sel_ext   = {2'b00, sel_frame};

  assign sts_o.hit         = hit;
  assign sts_o.policy_fifo = (mode_lat_q == PolicyFifo);
  assign sts_o.scan_last   = (cnt_q == FW'(NUM_FRAMES - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= PolicyLru;
      mode_lat_q  <= PolicyLru;
      fifo_ptr_q  <= '0;
      ref_cnt_q   <= '0;
      flt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_valid_q[i] <= 1'b0;
        frame_age_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (cmd_i.load_in) mode_lat_q <= mode_q;
      if (cmd_i.start_scan) cnt_q <= FW'(1);
      if (cmd_i.scan_step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        ref_cnt_q   <= sat_inc(ref_cnt_q);
        if (fault) begin
          flt_cnt_q                <= sat_inc(flt_cnt_q);
          frame_valid_q[sel_frame] <= 1'b1;
        end
        if (mode_lat_q == PolicyLru) begin
          for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_age_q[i] <= (FW'(i) == sel_frame) ? '0 : sat_inc(frame_age_q[i]);
          end
        end else if (fault) begin
          fifo_ptr_q <= (fifo_ptr_q == FW'(NUM_FRAMES - 1)) ? '0 : fifo_ptr_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) page_q <= page_in;
    if (cmd_i.start_scan) begin
      best_q     <= '0;
      best_age_q <= frame_age_q[0];
    end
    if (cmd_i.scan_step && (age_rd > best_age_q)) begin
      best_q     <= cnt_q;
      best_age_q <= age_rd;
    end
    if (cmd_i.commit) begin
      if (fault) frame_page_q[sel_frame] <= page_q;
      frame_out_q <= sel_ext[FrameOutW-1:0];
      fault_out_q <= fault;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_index_o     = frame_out_q;
  assign page_fault_o      = fault_out_q;
  assign reference_total_o = ref_cnt_q;
  assign fault_total_o     = flt_cnt_q;

endmodule

// File: hdl/page_frame_replacement_top.sv
// page-frame replacement table, fully associative over NUM_FRAMES frames
// input channel: in_valid_i / in_ready_o carry one page number per transfer
// output channel: out_valid_o / out_ready_i carry frame index, fault flag and
//   the running reference and fault totals, one result per input
// config: cfg_we_i writes cfg_wdata_i into the policy mode (0 lru, 1 fifo);
//   the user must write it only while no reference is in flight; the block does no check of this
// an lru miss takes longer than a hit or a fifo reference, because of the victim
//   scan that compares one frame age per cycle through a single age read port
// the result is registered at commit: after the lookup state on a hit or fifo
//   reference, after the victim scan and the update state on an lru miss
// one reference is worked on at a time; the next one is taken while a
//   finished result still waits in the output register
// a stalled receiver holds the result; the next reference then waits at
//   commit until the output register frees
// reset: all frames empty, ages and totals zero, fifo pointer zero, lru mode
module page_frame_replacement_top
  import pfr_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // reference input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PageInW-1:0]   page_number_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FrameOutW-1:0] frame_index_o,
  output logic                 page_fault_o,
  output logic [CntW-1:0]      reference_total_o,
  output logic [CntW-1:0]      fault_total_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: lookup, optional victim scan, commit
  pfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // frame table, ages, counters and output register
  pfr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .page_number_i     (page_number_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .frame_index_o     (frame_index_o),
    .page_fault_o      (page_fault_o),
    .reference_total_o (reference_total_o),
    .fault_total_o     (fault_total_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

// File: hdl/pfr_checker.sv
`include "page_frame_replacement_top_macros.svh"

module pfr_checker
  import pfr_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            page_fault_o,
  input logic [CntW-1:0] reference_total_o,
  input logic [CntW-1:0] fault_total_o
);

  // a reported fault has been counted
  `PFR_ASSERT_NOW(a_fault_counted, out_valid_o && page_fault_o, fault_total_o != '0)

  // faults never outrun references
  `PFR_ASSERT_NOW(a_fault_le_ref, out_valid_o, fault_total_o <= reference_total_o)

  // one reference at a time: no input right after a transfer
  `PFR_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  // stalled result stays offered
  `PFR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind page_frame_replacement_top pfr_checker u_pfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .page_fault_o      (page_fault_o),
  .reference_total_o (reference_total_o),
  .fault_total_o     (fault_total_o)
);

// File: tb/page_frame_replacement_top_test.sv
module page_frame_replacement_top_test;
  import pfr_pkg::*;

  localparam int unsigned Frames     = NumFramesDef;
  localparam int unsigned PageBits   = PageBitsDef;
  localparam int unsigned SettleWait = Frames + 4;   // longest reference latency plus margin
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseRefs  = 110;

  // one expected lookup outcome, in arrival order
  typedef struct {
    logic [FrameOutW-1:0] frame;
    logic                 fault;
    logic [CntW-1:0]      ref_total;
    logic [CntW-1:0]      fault_total;
  } lookup_t;

  // shadow of the frame table plus the queue of outcomes still owed by the block
  class frame_scoreboard;
    logic [PageBits-1:0] held_page[Frames];
    bit                  held[Frames];
    logic [CntW-1:0]     age[Frames];
    int unsigned         rr_ptr;
    logic [CntW-1:0]     ref_count;
    logic [CntW-1:0]     fault_count;
    logic                policy;
    lookup_t             owed[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         lru_refs;
    int unsigned         fifo_refs;

    function new();
      for (int i = 0; i < Frames; i++) begin
        held_page[i] = '0;
        held[i]      = 1'b0;
        age[i]       = '0;
      end
      rr_ptr      = 0;
      ref_count   = '0;
      fault_count = '0;
      policy      = PolicyLru;
      errors      = 0;
      checked     = 0;
      lru_refs    = 0;
      fifo_refs   = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // work out the outcome of one accepted page reference
    function void note_reference(logic [PageInW-1:0] page_in);
      logic [PageBits-1:0] page;
      int unsigned         frame;
      int unsigned         oldest;
      bit                  hit;
      bit                  fault;
      lookup_t             res;
      page  = page_in[PageBits-1:0];
      frame = 0;
      hit   = 1'b0;
      fault = 1'b0;
      for (int i = 0; i < Frames; i++) begin
        if (held[i] && held_page[i] == page) begin
          frame = i;
          hit   = 1'b1;
        end
      end
      if (policy == PolicyLru) begin
        lru_refs++;
        if (!hit) begin
          // lowest index wins a tie on age
          oldest = 0;
          for (int i = 1; i < Frames; i++) begin
            if (age[i] > age[oldest]) oldest = i;
          end
          frame = oldest;
          fault = 1'b1;
        end
        for (int i = 0; i < Frames; i++) begin
          if (i == frame) age[i] = '0;
          else if (age[i] != CntMax) age[i] = age[i] + 1'b1;
        end
      end else begin
        fifo_refs++;
        if (!hit) begin
          frame  = rr_ptr;
          rr_ptr = (rr_ptr + 1 >= Frames) ? 0 : rr_ptr + 1;
          fault  = 1'b1;
        end
      end
      if (fault) begin
        held_page[frame] = page;
        held[frame]      = 1'b1;
        if (fault_count != CntMax) fault_count = fault_count + 1'b1;
      end
      if (ref_count != CntMax) ref_count = ref_count + 1'b1;
      res.frame       = frame[FrameOutW-1:0];
      res.fault       = fault;
      res.ref_total   = ref_count;
      res.fault_total = fault_count;
      owed.push_back(res);
    endfunction

    // compare one result transfer against the oldest owed outcome
    function void check_result(logic [FrameOutW-1:0] frame, logic fault,
                               logic [CntW-1:0] ref_total, logic [CntW-1:0] fault_total);
      lookup_t want;
      if (owed.size() == 0) begin
        $error("result transfer with no reference outstanding (frame_index %0d)", frame);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (frame !== want.frame) begin
        $error("frame_index: expected %0d, got %0d", want.frame, frame);
        errors++;
      end
      if (fault !== want.fault) begin
        $error("page_fault: expected %0d, got %0d", want.fault, fault);
        errors++;
      end
      if (ref_total !== want.ref_total) begin
        $error("reference_total: expected %0d, got %0d", want.ref_total, ref_total);
        errors++;
      end
      if (fault_total !== want.fault_total) begin
        $error("fault_total: expected %0d, got %0d", want.fault_total, fault_total);
        errors++;
      end
    endfunction
  endclass

  // dut signals, the inputs known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_wdata_i   = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [PageInW-1:0]   page_number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [FrameOutW-1:0] frame_index_o;
  logic                 page_fault_o;
  logic [CntW-1:0]      reference_total_o;
  logic [CntW-1:0]      fault_total_o;

  frame_scoreboard sb;
  bit              steady_flow = 1'b0;   // no idling on either side while set

  page_frame_replacement_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .page_number_i    (page_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_index_o    (frame_index_o),
    .page_fault_o     (page_fault_o),
    .reference_total_o(reference_total_o),
    .fault_total_o    (fault_total_o)
  );

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) return $urandom_range(1, 3);
    else if (pick < 19) return $urandom_range(4, 8);
    else return $urandom_range(20, 40);
  endfunction

  // transfer monitor: results are checked before the new reference is noted,
  // since a result never belongs to the reference taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(frame_index_o, page_fault_o, reference_total_o, fault_total_o);
      if (in_valid_i && in_ready_o)
        sb.note_reference(page_number_i);
    end
  end

  // receiver side: random back-pressure, none while steady_flow is set
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_length()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // watchdog on the whole run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // offer one page reference and hold it until the transfer happens;
  // called right after a rising edge, valid is lowered only for a real gap
  task automatic send_page(logic [PageInW-1:0] page);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 2) == 0) gap = idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= page;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wait until every owed result has come back and the block has settled;
  // the first edge lets the monitor note a transfer taken at the calling edge
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // policy changes only with nothing in flight
  task automatic set_policy(logic mode);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.policy = mode;
  endtask

  initial begin
    logic [PageInW-1:0] lru_pages[9];
    logic [PageInW-1:0] fifo_pages[7];
    logic [PageInW-1:0] relru_pages[3];
    logic [PageInW-1:0] working_set[$];
    logic [PageInW-1:0] base;
    logic               mode;
    int unsigned        set_size;

    lru_pages   = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                    16'h0000, 16'h1234, 16'hFFFF, 16'h0000,
                    16'h8001};
    fifo_pages  = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                    16'hFFFE, 16'h7FFF, 16'h4321};
    relru_pages = '{16'h8000, 16'hABCD, 16'h0001};

    sb = new();

    // reset held from time zero, released once
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lru fill in index order, hits, evictions of the oldest frame
    set_policy(PolicyLru);
    foreach (lru_pages[i]) send_page(lru_pages[i]);

    // directed: fifo keeps the table, hits leave it alone, pointer wraps
    set_policy(PolicyFifo);
    foreach (fifo_pages[i]) send_page(fifo_pages[i]);

    // back to lru with the table and ages carried over
    set_policy(PolicyLru);
    foreach (relru_pages[i]) send_page(relru_pages[i]);

    // random phases: a small working set gives hits, the rest is noise
    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 2) mode = phase[0];
      else mode = 1'($urandom_range(0, 1));
      set_policy(mode);
      steady_flow = (phase % 4 == 3);

      // working set around one base page, near-misses differ in a single bit
      working_set.delete();
      base     = PageInW'($urandom_range(0, 16'hFFFF));
      set_size = $urandom_range(2, Frames + 3);
      working_set.push_back(base);
      for (int k = 1; k < set_size; k++) begin
        if ($urandom_range(0, 1) == 0)
          working_set.push_back(base ^ (16'h0001 << $urandom_range(0, PageInW - 1)));
        else
          working_set.push_back(PageInW'($urandom_range(0, 16'hFFFF)));
      end

      for (int n = 0; n < PhaseRefs; n++) begin
        if ($urandom_range(0, 4) != 0)
          send_page(working_set[$urandom_range(0, working_set.size() - 1)]);
        else
          send_page(PageInW'($urandom_range(0, 16'hFFFF)));
      end
    end

    steady_flow = 1'b0;
    in_valid_i <= 1'b0;
    wait_idle();

    $display("checked %0d references (%0d lru, %0d fifo), %0d faults counted",
             sb.checked, sb.lru_refs, sb.fifo_refs, sb.fault_count);
    $display("policy switched between phases with the table kept, %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
